[sv/ssm_pkg.sv]
`default_nettype none
package ssm_pkg;

   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;
   localparam int MODE_W  = 2;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 1;

   // input item codes
   localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

   // set_operation codes
   localparam logic [MODE_W-1:0] MODE_UNION     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;

   // register byte addresses
   localparam logic [ADDR_W-1:0] CSR_ADDR_SET_OPERATION = 1'd0;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic start;
      logic step;
      logic finish;
   } ssm_cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } ssm_stat_type;

endpackage
`default_nettype wire

[sv/ssm_req_if.sv]
`default_nettype none
interface ssm_req_if;
   logic                             valid;
   logic                             ready;
   logic [ssm_pkg::OP_W-1:0]         op;
   logic signed [ssm_pkg::VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

[sv/ssm_rsp_if.sv]
`default_nettype none
interface ssm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ssm_pkg::VALUE_W-1:0] element;
   logic                               last;
   logic                               empty_res;
   logic                               overflow;

   modport source (output valid, output element, output last, output empty_res,
                   output overflow, input ready);
   modport sink   (input valid, input element, input last, input empty_res,
                   input overflow, output ready);
endinterface
`default_nettype wire

[sv/ssm_ctrl.sv]
`default_nettype none
module ssm_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire [ssm_pkg::OP_W-1:0]   req_op,
   output logic                      req_ready,
   input  ssm_pkg::ssm_stat_type     stat,
   output ssm_pkg::ssm_cmd_type      cmd
);
   import ssm_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_LOAD_FIRST:  cmd.load_a = 1'b1;
                  OP_LOAD_SECOND: cmd.load_b = 1'b1;
                  OP_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_MERGE;
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            // one merge step or the closing push per free output slot
            if (stat.out_free) begin
               if (stat.done) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[sv/ssm_dp.sv]
`default_nettype none
module ssm_dp #(
   parameter int SET_DEPTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  ssm_pkg::ssm_cmd_type               cmd,
   output ssm_pkg::ssm_stat_type              stat,
   input  wire [ssm_pkg::MODE_W-1:0]          mode,
   input  wire signed [ssm_pkg::VALUE_W-1:0]  load_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [ssm_pkg::VALUE_W-1:0] rsp_element,
   output logic                               rsp_last,
   output logic                               rsp_empty_res,
   output logic                               rsp_overflow
);
   import ssm_pkg::*;

   localparam int CNT_W = $clog2(SET_DEPTH + 1);
   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   logic [VALUE_W-1:0] first_mem  [SET_DEPTH];
   logic [VALUE_W-1:0] second_mem [SET_DEPTH];

   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]   ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic signed [VALUE_W-1:0] head_a_ff, head_b_ff;
   logic               dropped_ff, dropped_in;
   logic signed [VALUE_W-1:0] pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] out_elem_ff, out_elem_in;
   logic               out_last_ff, out_last_in, out_empty_ff, out_empty_in;
   logic               out_ovf_ff, out_ovf_in;

   logic a_ok, b_ok, take_a, take_b, take_eq, emit;
   logic full_a, full_b;

   assign full_a = (cnt_a_ff >= DEPTH_C);
   assign full_b = (cnt_b_ff >= DEPTH_C);

   // merge step: exhausted side counts as larger than anything
   always_comb begin
      a_ok    = ptr_a_ff < cnt_a_ff;
      b_ok    = ptr_b_ff < cnt_b_ff;
      take_a  = a_ok && (!b_ok || (head_a_ff < head_b_ff));
      take_b  = !take_a && b_ok && (!a_ok || (head_b_ff < head_a_ff));
      take_eq = !take_a && !take_b;
      case (mode)
         MODE_UNION:     emit = 1'b1;
         MODE_INTERSECT: emit = take_eq;
         MODE_DIFF:      emit = take_a;
         default:        emit = 1'b0;
      endcase
   end

   assign stat.done     = !a_ok && !b_ok;
   assign stat.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ptr_a_in      = ptr_a_ff;
      ptr_b_in      = ptr_b_ff;
      dropped_in    = dropped_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_elem_in   = out_elem_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      out_ovf_in    = out_ovf_ff;

      if (cmd.load_a) begin
         if (full_a) dropped_in = 1'b1;
         else        cnt_a_in   = cnt_a_ff + ONE_C;
      end
      if (cmd.load_b) begin
         if (full_b) dropped_in = 1'b1;
         else        cnt_b_in   = cnt_b_ff + ONE_C;
      end
      if (cmd.start) begin
         ptr_a_in      = '0;
         ptr_b_in      = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.step) begin
         if (take_a || take_eq) ptr_a_in = ptr_a_ff + ONE_C;
         if (take_b || take_eq) ptr_b_in = ptr_b_ff + ONE_C;
         if (emit) begin
            // hold one element back so the final one can carry last
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_elem_in  = pend_ff;
               out_last_in  = 1'b0;
               out_empty_in = 1'b0;
               out_ovf_in   = dropped_ff;
            end
            pend_in       = take_b ? head_b_ff : head_a_ff;
            pend_valid_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_elem_in   = pend_valid_ff ? pend_ff : '0;
         out_last_in   = 1'b1;
         out_empty_in  = !pend_valid_ff;
         out_ovf_in    = dropped_ff;
         pend_valid_in = 1'b0;
         cnt_a_in      = '0;
         cnt_b_in      = '0;
      end
   end

   // set stores, read data registered at the next pointer
   always_ff @(posedge clock) begin
      if (cmd.load_a && !full_a) first_mem[cnt_a_ff[IDX_W-1:0]] <= load_value;
      if (cmd.load_b && !full_b) second_mem[cnt_b_ff[IDX_W-1:0]] <= load_value;
      head_a_ff <= first_mem[ptr_a_in[IDX_W-1:0]];
      head_b_ff <= second_mem[ptr_b_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ptr_a_ff      <= '0;
         ptr_b_ff      <= '0;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ptr_a_ff      <= ptr_a_in;
         ptr_b_ff      <= ptr_b_in;
         dropped_ff    <= dropped_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      out_elem_ff  <= out_elem_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_element   = out_elem_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_empty_res = out_empty_ff;
   assign rsp_overflow  = out_ovf_ff;

endmodule
`default_nettype wire

[sv/sorted_set_merge_ops.sv]
`default_nettype none
// sorted set merge unit
// req_chan: op 0 loads value into the first set, op 1 into the second set,
//    op 2 runs the merge selected by the set_operation register
//    (0 union, 1 intersection, 2 first minus second); op 3 is ignored
// rsp_chan: the run's answer in ascending order, last on the final transfer;
//    an empty answer is one transfer with empty_res set and element 0;
//    overflow is sticky and reports loads dropped into a full set
// csr: APB-style, set_operation at byte address 0, write only while idle
// loads are accepted back to back while no run is in progress
// a run does one merge step per cycle while the output slot is free, up to
//    na + nb steps, then the closing transfer; the step loop over the two
//    store read ports sets that rate; new items wait until the run has
//    pushed its last transfer into the output register
// a stalled receiver holds the merge: a step waits for a free output slot
// reset empties both sets, clears overflow and set_operation and drops any
//    transfer in flight
module sorted_set_merge_ops #(
   parameter int SET_DEPTH = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   ssm_req_if.sink                       req_chan,
   ssm_rsp_if.source                     rsp_chan,
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire [ssm_pkg::ADDR_W-1:0]     csr_paddr,
   input  wire [ssm_pkg::CSR_W-1:0]      csr_pwdata,
   output logic [ssm_pkg::CSR_W-1:0]     csr_prdata,
   output logic                          csr_pready
);
   import ssm_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;
   logic              csr_write;
   ssm_cmd_type       cmd;
   ssm_stat_type      stat;

   // register port, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (csr_paddr == CSR_ADDR_SET_OPERATION)) begin
         mode_in = csr_pwdata[MODE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_SET_OPERATION) begin
         csr_prdata = {{(CSR_W-MODE_W){1'b0}}, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNION;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // sequencer: load decode, step pacing, closing transfer
   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // set stores, pointers, compare and output register
   ssm_dp #(
      .SET_DEPTH (SET_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .mode          (mode_ff),
      .load_value    (req_chan.value),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_element   (rsp_chan.element),
      .rsp_last      (rsp_chan.last),
      .rsp_empty_res (rsp_chan.empty_res),
      .rsp_overflow  (rsp_chan.overflow)
   );

endmodule
`default_nettype wire

[verif/tb.sv]
module tb;
   import ssm_pkg::*;

   localparam int DEPTH      = 16;
   localparam int MAX_CYCLES = 400000;
   // a run is done once its last transfer is out; SETTLE adds a margin
   localparam int SETTLE     = 6;

   // codes the package leaves unnamed: both are legal field values
   localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // values at the corners of the signed range
   localparam int EXTREMES [7] = '{32'h8000_0000, 32'h8000_0001, -1, 0, 1,
                                   32'h7FFF_FFFE, 32'h7FFF_FFFF};

   typedef struct packed {
      logic signed [VALUE_W-1:0] element;
      logic                      last;
      logic                      empty_res;
      logic                      overflow;
   } merge_out_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one row of the directed table: an input item or a register write;
   // typed rows carry their answer, the others go to the predictor
   typedef struct packed {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [MODE_W-1:0] mode;
      logic [VALUE_W-1:0] value;
      logic              typed;
      merge_out_type     answer;
   } stim_row_type;

   typedef struct packed {
      logic          typed;
      merge_out_type answer;
   } run_note_type;

   localparam merge_out_type EMPTY_ANSWER = '{element: '0, last: 1'b1, empty_res: 1'b1,
                                              overflow: 1'b0};
   localparam merge_out_type NO_ANSWER    = '0;

   localparam int N_DIRECTED = 30;

   stim_row_type directed [N_DIRECTED] = '{
      // run straight after reset: both sets empty
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b1, EMPTY_ANSWER},
      // union over the corners of the range, the top value included
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'h8000_0000, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'hFFFF_FFFF, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'h7FFF_FFFE, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'hFFFF_FFFF, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'h0000_0000, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'h7FFF_FFFF, 1'b0, NO_ANSWER},
      // unused op code, must leave the sets alone
      '{ROW_ITEM, OP_UNUSED,      MODE_UNION,     32'h5555_AAAA, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'hAAAA_5555, 1'b0, NO_ANSWER},
      // intersection on the top value, which an exhausted set must still exceed
      '{ROW_CSR,  OP_RUN,         MODE_INTERSECT, 32'h0,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'h7FFF_FFFF, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'h7FFF_FFFF, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b0, NO_ANSWER},
      // difference: equal heads cancel, a lone second set gives nothing
      '{ROW_CSR,  OP_RUN,         MODE_DIFF,      32'h0,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'h8000_0000, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'h8000_0000, 1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b1, EMPTY_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'd3,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b1, EMPTY_ANSWER},
      // unused operation code: empty answer, sets still cleared
      '{ROW_CSR,  OP_RUN,         MODE_UNUSED,    32'h0,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'd4,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'd4,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b1, EMPTY_ANSWER},
      // unsorted first set with a repeat, merged as stored
      '{ROW_CSR,  OP_RUN,         MODE_UNION,     32'h0,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'd9,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'd1,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_FIRST,  MODE_UNION,     32'd9,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_LOAD_SECOND, MODE_UNION,     32'd5,         1'b0, NO_ANSWER},
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b0, NO_ANSWER},
      // the previous run emptied both sets
      '{ROW_ITEM, OP_RUN,         MODE_UNION,     32'h0,         1'b1, EMPTY_ANSWER}
   };

   logic clock;
   logic reset;

   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [CSR_W-1:0]   csr_pwdata;
   logic [CSR_W-1:0]   csr_prdata;
   logic               csr_pready;

   ssm_req_if req_if ();
   ssm_rsp_if rsp_if ();

   sorted_set_merge_ops #(.SET_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state: the two stores, their fill levels, the sticky drop
   // flag and the selected operation
   logic signed [VALUE_W-1:0] first_held  [DEPTH];
   logic signed [VALUE_W-1:0] second_held [DEPTH];
   int                        first_fill;
   int                        second_fill;
   logic                      drop_seen;
   logic [MODE_W-1:0]         merge_mode;

   merge_out_type merge_answers_due [$];   // answers still to come out, oldest first
   run_note_type  run_notes [$];           // typed answers of directed runs, in order

   int   errors;
   int   items_sent;
   int   cycle_count;
   int   idle_pct;
   int   stall_pct;
   logic rsp_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == MAX_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off while rsp_hold is set
   always @(posedge clock)
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);

   // predictor: update state on every accepted item, queue a run's answer
   task automatic predict_merge(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
      merge_out_type fresh [$];
      merge_out_type r;
      run_note_type  note;
      int            i;
      int            j;
      logic          emit;
      logic signed [VALUE_W-1:0] e;
      case (op)
         OP_LOAD_FIRST: begin
            if (first_fill < DEPTH) begin
               first_held[first_fill] = v;
               first_fill++;
            end else
               drop_seen = 1'b1;
         end
         OP_LOAD_SECOND: begin
            if (second_fill < DEPTH) begin
               second_held[second_fill] = v;
               second_fill++;
            end else
               drop_seen = 1'b1;
         end
         OP_RUN: begin
            i = 0;
            j = 0;
            // two-pointer walk; an exhausted side loses every comparison
            if (merge_mode != MODE_UNUSED) begin
               while (i < first_fill || j < second_fill) begin
                  emit = 1'b0;
                  e = '0;
                  if (i < first_fill && (j >= second_fill || first_held[i] < second_held[j])) begin
                     emit = (merge_mode == MODE_UNION || merge_mode == MODE_DIFF);
                     e = first_held[i];
                     i++;
                  end else if (j < second_fill &&
                               (i >= first_fill || second_held[j] < first_held[i])) begin
                     emit = (merge_mode == MODE_UNION);
                     e = second_held[j];
                     j++;
                  end else begin
                     // equal heads go together
                     emit = (merge_mode == MODE_UNION || merge_mode == MODE_INTERSECT);
                     e = first_held[i];
                     i++;
                     j++;
                  end
                  if (emit && fresh.size() < 2 * DEPTH) begin
                     r = '{element: e, last: 1'b0, empty_res: 1'b0, overflow: drop_seen};
                     fresh.push_back(r);
                  end
               end
            end
            if (fresh.size() == 0) begin
               r = '{element: '0, last: 1'b1, empty_res: 1'b1, overflow: drop_seen};
               fresh.push_back(r);
            end else
               fresh[fresh.size() - 1].last = 1'b1;
            first_fill = 0;
            second_fill = 0;
            note = '0;
            if (run_notes.size() != 0)
               note = run_notes.pop_front();
            if (note.typed)
               merge_answers_due.push_back(note.answer);
            else
               foreach (fresh[q]) merge_answers_due.push_back(fresh[q]);
         end
         default: ;   // unused op: nothing happens
      endcase
   endtask

   // checker: result transfers against the oldest answer, then new items
   // into the predictor; all values sampled as they were before the edge
   always @(posedge clock) begin
      merge_out_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (merge_answers_due.size() == 0) begin
               $error("unexpected result transfer: element %0d", rsp_if.element);
               errors++;
            end else begin
               want = merge_answers_due.pop_front();
               if (rsp_if.element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp_if.element);
                  errors++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_if.last);
                  errors++;
               end
               if (rsp_if.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0b, got %0b", want.empty_res, rsp_if.empty_res);
                  errors++;
               end
               if (rsp_if.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_if.overflow);
                  errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            predict_merge(req_if.op, req_if.value);
      end
   end

   // offer one item after a random idle gap, return at its transfer edge
   task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= op;
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   // stop offering and let every pending answer come out
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (merge_answers_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write, then read back
   task automatic write_set_operation(input logic [MODE_W-1:0] m);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_SET_OPERATION;
      csr_pwdata  <= CSR_W'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      merge_mode = m;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_W'(m)) begin
         $error("set_operation: expected %0d, got %0d", m, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // long receiver hold-off in a process of its own
   task automatic hold_receiver(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // style 0 packs values into a narrow window so heads collide often,
   // style 1 spreads them over the full range, style 2 sits on the corners
   function automatic int pick_value(input int style, input int base);
      case (style)
         0:       return base + int'($urandom_range(40));
         1:       return int'($urandom());
         default: return EXTREMES[$urandom_range(6)];
      endcase
   endfunction

   // one well-formed load sequence with random content, ending in a run
   task automatic merge_sequence(input int max_load);
      int a_vals [$];
      int b_vals [$];
      int na;
      int nb;
      int ia;
      int ib;
      int style;
      int base;
      int x;
      int y;
      int t;
      na = ($urandom_range(3) == 0) ? $urandom_range(max_load) : $urandom_range(6);
      nb = ($urandom_range(3) == 0) ? $urandom_range(max_load) : $urandom_range(6);
      style = $urandom_range(2);
      base = $urandom();
      repeat (na) a_vals.push_back(pick_value(style, base));
      // about half the second set is shared with the first
      repeat (nb)
         b_vals.push_back((na != 0 && $urandom_range(1) == 0) ?
                          a_vals[$urandom_range(na - 1)] : pick_value(style, base));
      a_vals.sort();
      b_vals.sort();
      // now and then a first set out of order
      if (na > 1 && $urandom_range(9) == 0) begin
         x = $urandom_range(na - 1);
         y = $urandom_range(na - 1);
         t = a_vals[x];
         a_vals[x] = a_vals[y];
         a_vals[y] = t;
      end
      ia = 0;
      ib = 0;
      // loads of the two sets interleaved at random, some noise between
      while (ia < na || ib < nb) begin
         if ($urandom_range(19) == 0)
            send_item(OP_UNUSED, $urandom());
         if (ib >= nb || (ia < na && $urandom_range(1) == 0)) begin
            send_item(OP_LOAD_FIRST, a_vals[ia]);
            ia++;
         end else begin
            send_item(OP_LOAD_SECOND, b_vals[ib]);
            ib++;
         end
      end
      send_item(OP_RUN, $urandom());
   endtask

   // sequences until the item count reaches target, with mode changes
   task automatic run_phase(input int target, input int max_load);
      while (items_sent < target) begin
         if ($urandom_range(2) == 0) begin
            wait_idle();
            write_set_operation(($urandom_range(9) == 0) ? MODE_UNUSED
                                                          : MODE_W'($urandom_range(2)));
         end
         merge_sequence(max_load);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.op    = OP_LOAD_FIRST;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      first_fill   = 0;
      second_fill  = 0;
      drop_seen    = 1'b0;
      merge_mode   = MODE_UNION;
      errors       = 0;
      items_sent   = 0;
      cycle_count  = 0;
      idle_pct     = 0;
      stall_pct    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed[k]) begin
         if (directed[k].kind == ROW_CSR) begin
            wait_idle();
            write_set_operation(directed[k].mode);
         end else begin
            if (directed[k].op == OP_RUN)
               run_notes.push_back('{directed[k].typed, directed[k].answer});
            send_item(directed[k].op, directed[k].value);
         end
      end

      // random part: no idling, sender idle, receiver stalling, both
      run_phase(95, DEPTH);
      idle_pct = 77;
      run_phase(165, DEPTH);
      idle_pct = 0;
      stall_pct = 77;
      run_phase(235, DEPTH);
      idle_pct = 20;
      stall_pct = 20;
      run_phase(305, DEPTH);

      // receiver holds off while items keep coming, so the input backs up
      idle_pct = 0;
      stall_pct = 0;
      wait_idle();
      fork
         hold_receiver(300);
      join_none
      run_phase(365, DEPTH);

      // overfilled sets last, since the drop flag stays set until reset
      idle_pct = 20;
      stall_pct = 20;
      run_phase(470, DEPTH + 2);

      wait_idle();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
sv/ssm_pkg.sv
sv/ssm_req_if.sv
sv/ssm_rsp_if.sv
sv/ssm_ctrl.sv
sv/ssm_dp.sv
sv/sorted_set_merge_ops.sv
verif/tb.sv
